FILE: design/qse_pkg.sv
// qse_pkg: shared types and character constants for the quoted string escaper
// used by the front classifier, the entry queue, the back serializer and the top level
package qse_pkg;

  localparam int unsigned MaxChars = 5;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = 1;
  localparam int unsigned QCntW    = 2;

  localparam logic [7:0] DQ_CHAR   = 8'h22;
  localparam logic [7:0] SQ_CHAR   = 8'h27;
  localparam logic [7:0] BSL_CHAR  = 8'h5C;
  localparam logic [7:0] SPACE_LIM = 8'h20;
  localparam logic [7:0] DEL_CHAR  = 8'h7F;
  localparam logic [7:0] NUL_CHAR  = 8'h00;

  localparam logic [7:0] NL_CHAR   = 8'h0A;
  localparam logic [7:0] TAB_CHAR  = 8'h09;
  localparam logic [7:0] CR_CHAR   = 8'h0D;
  localparam logic [7:0] BS_CHAR   = 8'h08;
  localparam logic [7:0] FF_CHAR   = 8'h0C;

  localparam logic [7:0] LTR_N     = 8'h6E;
  localparam logic [7:0] LTR_T     = 8'h74;
  localparam logic [7:0] LTR_R     = 8'h72;
  localparam logic [7:0] LTR_B     = 8'h62;
  localparam logic [7:0] LTR_F     = 8'h66;
  localparam logic [7:0] DIGIT_0   = 8'h30;
  localparam logic [7:0] DIGIT_1   = 8'h31;

  // one classified input word: characters in send order and index of the last one
  typedef struct packed {
    logic [MaxChars-1:0][7:0] chars;
    logic [IdxW-1:0]          last_idx;
  } entry_t;

  // octal digit character for a 3-bit value
  function automatic logic [7:0] octal_char(input logic [2:0] v);
    octal_char = {5'b00110, v};
  endfunction

endpackage

FILE: design/quoted_string_escaper.sv
// quoted_string_escaper: top level, writes a byte stream as a double-quoted C literal
// depends on qse_pkg, qse_front, qse_queue, qse_back
//
//   channel  | dir | tdata           | tuser            | tlast
//   s_axis   | in  | data_byte [7:0] | start_of_string  | -
//   m_axis   | out | out_byte [7:0]  | -                | last_of_run
//
// each input byte yields 1 to 5 output words, one per cycle while m_axis_tready is high
// plain bytes sustain one byte per cycle while m_axis_tready is high; escapes are slower
// a two-entry queue lets the input keep flowing while the output is stalled, until it fills
// a taken byte is written into the queue and then loaded into the serializer before it leaves
// reset empties the queue and idles the serializer; no clearing pass is needed
module quoted_string_escaper
  import qse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // data_byte
  input  logic       s_axis_tuser,  // start_of_string
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // out_byte
  output logic       m_axis_tlast   // last_of_run
);

  logic   q_wr, q_full, q_rd, q_valid;
  entry_t wr_entry, rd_entry;

  qse_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .q_wr_o        (q_wr),
    .q_entry_o     (wr_entry)
  );

  qse_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (q_wr),
    .wr_entry_i (wr_entry),
    .full_o     (q_full),
    .rd_i       (q_rd),
    .valid_o    (q_valid),
    .rd_entry_o (rd_entry)
  );

  qse_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (rd_entry),
    .q_rd_o        (q_rd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: design/qse_front.sv
// qse_front: accepts input bytes, escapes each, adds the opening quote and turns NUL into a quote
// depends on qse_pkg
module qse_front
  import qse_pkg::*;
(
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // data_byte
  input  logic       s_axis_tuser,  // start_of_string
  input  logic       q_full_i,
  output logic       q_wr_o,
  output entry_t     q_entry_o
);

  logic [3:0][7:0] body;
  logic [IdxW-1:0] body_last;
  logic [7:0]      b;

  assign b             = s_axis_tdata;
  assign s_axis_tready = !q_full_i;
  assign q_wr_o        = s_axis_tvalid && !q_full_i;

  always_comb begin
    body      = '0;
    body_last = '0;
    case (b)
      NUL_CHAR: begin
        body[0] = DQ_CHAR;
      end
      NL_CHAR: begin
        body[0] = BSL_CHAR; body[1] = LTR_N; body_last = 3'd1;
      end
      TAB_CHAR: begin
        body[0] = BSL_CHAR; body[1] = LTR_T; body_last = 3'd1;
      end
      CR_CHAR: begin
        body[0] = BSL_CHAR; body[1] = LTR_R; body_last = 3'd1;
      end
      BS_CHAR: begin
        body[0] = BSL_CHAR; body[1] = LTR_B; body_last = 3'd1;
      end
      FF_CHAR: begin
        body[0] = BSL_CHAR; body[1] = LTR_F; body_last = 3'd1;
      end
      BSL_CHAR, SQ_CHAR, DQ_CHAR: begin
        body[0] = BSL_CHAR; body[1] = b; body_last = 3'd1;
      end
      default: begin
        if (b >= SPACE_LIM && b != DEL_CHAR) begin
          body[0] = b;
        end else begin
          // control codes and delete go out as three octal digits
          body[0]   = BSL_CHAR;
          body[1]   = octal_char({1'b0, b[7:6]});
          body[2]   = octal_char(b[5:3]);
          body[3]   = octal_char(b[2:0]);
          body_last = 3'd3;
        end
      end
    endcase
  end

  always_comb begin
    if (s_axis_tuser) begin
      q_entry_o.chars    = {body, DQ_CHAR};
      q_entry_o.last_idx = body_last + 3'd1;
    end else begin
      q_entry_o.chars    = {8'h00, body};
      q_entry_o.last_idx = body_last;
    end
  end

endmodule

FILE: design/qse_queue.sv
// qse_queue: short first-in first-out queue of classified entries between front and back
// depends on qse_pkg
module qse_queue
  import qse_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_i,
  input  entry_t wr_entry_i,
  output logic   full_o,
  input  logic   rd_i,
  output logic   valid_o,
  output entry_t rd_entry_o
);

  entry_t            mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  assign full_o     = (cnt_q == QCntW'(QDepth));
  assign valid_o    = (cnt_q != '0);
  assign rd_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

endmodule

FILE: design/qse_back.sv
// qse_back: holds one entry and sends its characters one word per cycle while m_axis_tready is high
// depends on qse_pkg
module qse_back
  import qse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  entry_t     q_entry_i,
  output logic       q_rd_o,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // out_byte
  output logic       m_axis_tlast   // last_of_run
);

  entry_t          cur_q, cur_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            busy_q, busy_d;
  logic            xfer;

  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = cur_q.chars[idx_q];
  assign m_axis_tlast  = (idx_q == cur_q.last_idx);
  assign xfer          = busy_q && m_axis_tready;
  // take the next entry when empty or as the final word of this one leaves
  assign q_rd_o        = q_valid_i && (!busy_q || (xfer && m_axis_tlast));

  always_comb begin
    cur_d  = cur_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    if (q_rd_o) begin
      cur_d  = q_entry_i;
      idx_d  = '0;
      busy_d = 1'b1;
    end else if (xfer) begin
      if (m_axis_tlast) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

FILE: design/qse_checker.sv
// qse_checker: port-level assertions for quoted_string_escaper, attached by bind
// depends on qse_pkg and the top-level ports
module qse_checker
  import qse_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  logic       in_xfer, out_xfer, out_end;
  logic [2:0] pend_q, pend_d;
  logic       after_bsl_q, after_bsl_d;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign out_end  = out_xfer && m_axis_tlast;

  // bytes taken whose final word has not left yet
  always_comb begin
    pend_d = pend_q + {2'b00, in_xfer} - {2'b00, out_end};
    after_bsl_d = after_bsl_q;
    if (out_xfer) begin
      after_bsl_d = (m_axis_tdata == BSL_CHAR) && !m_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      after_bsl_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      after_bsl_q <= after_bsl_d;
    end
  end

  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 3'd0)
    else $error("output word with no byte outstanding");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("more bytes outstanding than queue and serializer hold");

  a_escape_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && after_bsl_q) |->
      (m_axis_tdata == LTR_N || m_axis_tdata == LTR_T || m_axis_tdata == LTR_R ||
       m_axis_tdata == LTR_B || m_axis_tdata == LTR_F || m_axis_tdata == BSL_CHAR ||
       m_axis_tdata == SQ_CHAR || m_axis_tdata == DQ_CHAR || m_axis_tdata == DIGIT_0 ||
       m_axis_tdata == DIGIT_1))
    else $error("bad character after escape backslash");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled output word changed");

endmodule

bind quoted_string_escaper qse_checker u_qse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
